[hw/rtl/straight_segment_drive_controller_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the straight segment drive controller
// Shared clocking and reset handling for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STRAIGHT_SEGMENT_DRIVE_CONTROLLER_ASSERT_SVH
`define STRAIGHT_SEGMENT_DRIVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SSDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SSDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssdc_pkg.sv]
// ----------------------------------------------------------------------------
// ssdc_pkg
// Types and constants shared by the straight segment drive controller.
// ----------------------------------------------------------------------------
package ssdc_pkg;

    localparam int HEAD_WIDTH     = 13;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int TARGET_WIDTH   = 16;
    localparam int GAIN_WIDTH     = 15;
    localparam int OUT_WIDTH      = 16;
    // heading error working width: holds any 14-bit difference and +/- 2*pi
    localparam int HERR_WIDTH     = 18;
    // squared distance saturates at this many bits
    localparam int SUM_LIMIT_BITS = 64;

    localparam int OUT_POS_LIMIT  = 32767;
    localparam int OUT_NEG_LIMIT  = 32768;

    // pi with 30 fraction bits, rounded to nearest in the working format at elaboration
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 16'sh8000;

    localparam logic [0:0] CMD_START  = 1'b0;
    localparam logic [0:0] CMD_SAMPLE = 1'b1;

    localparam logic signed [TARGET_WIDTH-1:0] RST_TARGET_DISTANCE = 16'sd2560;
    localparam logic [GAIN_WIDTH-1:0] RST_CRUISE_SPEED    = 15'd1536;
    localparam logic [GAIN_WIDTH-1:0] RST_SLOWDOWN_RADIUS = 15'd512;
    localparam logic [GAIN_WIDTH-1:0] RST_MIN_SPEED       = 15'd154;
    localparam logic [GAIN_WIDTH-1:0] RST_STOP_TOLERANCE  = 15'd20;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_TARGET_DISTANCE = 3'd0,
        CFG_CRUISE_SPEED    = 3'd1,
        CFG_SLOWDOWN_RADIUS = 3'd2,
        CFG_MIN_SPEED       = 3'd3,
        CFG_STOP_TOLERANCE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH
    } t_state;

endpackage

[hw/rtl/straight_segment_drive_controller.sv]
// ----------------------------------------------------------------------------
// straight_segment_drive_controller
// Proportional approach controller with heading hold for a straight segment.
// ----------------------------------------------------------------------------
// Pose items arrive on the s_axis channel: tuser is the command (0 starts a
// segment at this pose, 1 is an ordinary sample), tdata carries x, y and
// heading. Every item gives exactly one result on m_axis: linear and angular
// commands in tdata, the done flag in tuser.
// The user must write settings through the cfg port only while no item is
// in flight; the block itself does not enforce it. One item is in work at a
// time, so the next transfer can be taken once the result is registered. The
// squarers (two bits per cycle) and the square root (two root bits per cycle)
// set how long an item takes; at small FRAC_BITS the heading wrap, one turn
// per cycle, can take longer. A sample with no segment open skips the
// arithmetic and answers with a done result of zero commands.
// Reset loads the default settings and closes any segment; no result is
// pending. A result waits in the output register while the receiver stalls;
// the block still takes the next item, which then waits in the finish state.
// ----------------------------------------------------------------------------
`include "straight_segment_drive_controller_assert.svh"

module straight_segment_drive_controller #(
    parameter int FRAC_BITS  = 10,
    parameter int POSE_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_wr_en,
    input  logic [ssdc_pkg::CFG_IDX_WIDTH-1:0]       i_cfg_idx,
    input  logic [ssdc_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_wdata,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // pose_x, pose_y, pose_heading, zero pad to whole bytes
    input  logic [((2*POSE_WIDTH+ssdc_pkg::HEAD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // linear_cmd, angular_cmd
    output logic [2*ssdc_pkg::OUT_WIDTH-1:0]         m_axis_tdata,
    // done_res
    output logic                                     m_axis_tuser
);

    import ssdc_pkg::*;

    localparam int W      = POSE_WIDTH;
    localparam int QW     = W + 1;
    localparam int ROOT_W = QW + (QW % 2);
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SUM_W  = 2 * W + 1;
    localparam int REMW   = ((QW > TARGET_WIDTH + 1) ? QW : TARGET_WIDTH + 1) + 1;
    localparam int MAG_W  = REMW + 1;

    // configuration
    logic signed [TARGET_WIDTH-1:0] r_target;
    logic [GAIN_WIDTH-1:0]          r_cruise;
    logic [GAIN_WIDTH-1:0]          r_slow;
    logic [GAIN_WIDTH-1:0]          r_min_speed;
    logic [GAIN_WIDTH-1:0]          r_stop_tol;

    // segment state
    logic signed [W-1:0]            r_start_x, n_start_x;
    logic signed [W-1:0]            r_start_y, n_start_y;
    logic signed [HEAD_WIDTH-1:0]   r_start_h, n_start_h;
    logic                           r_active, n_active;
    logic                           r_skip, n_skip;
    t_state                         r_state, n_state;
    logic signed [REMW-1:0]         r_rem, n_rem;

    // output register
    logic                           r_m_valid, n_m_valid;
    logic [2*OUT_WIDTH-1:0]         r_m_data, n_m_data;
    logic                           r_m_done, n_m_done;

    // input fields
    logic signed [W-1:0]            w_px, w_py;
    logic signed [HEAD_WIDTH-1:0]   w_ph;
    logic                           w_accept, w_cmd_start;
    logic signed [W:0]              w_dx, w_dy;
    logic [W-1:0]                   w_ax, w_ay;
    logic signed [HEAD_WIDTH:0]     w_dh;

    // unit handshakes
    logic                           w_sq_start, w_rt_start, w_wr_start;
    logic                           w_sqx_busy, w_sqy_busy, w_rt_busy, w_wr_busy;
    logic [2*W-1:0]                 w_sqx, w_sqy;
    logic [SUM_W-1:0]               w_sum, w_sum_clip;
    logic [ROOT_W-1:0]              w_root;
    logic signed [HERR_WIDTH-1:0]   w_err;

    // finishing arithmetic
    logic [TARGET_WIDTH:0]          w_tgt_abs;
    logic                           w_reached, w_near;
    logic [MAG_W-1:0]               w_twice, w_min_m, w_mag;
    logic signed [OUT_WIDTH-1:0]    w_lin, w_ang;
    logic signed [HERR_WIDTH:0]     w_err2;
    logic                           w_out_free;

    assign w_px        = s_axis_tdata[W-1:0];
    assign w_py        = s_axis_tdata[2*W-1:W];
    assign w_ph        = s_axis_tdata[2*W+HEAD_WIDTH-1:2*W];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_cmd_start = (s_axis_tuser == CMD_START);

    // a start measures from its own pose, so every difference is zero
    assign w_dx = w_cmd_start ? '0 : ((W+1)'(w_px) - (W+1)'(r_start_x));
    assign w_dy = w_cmd_start ? '0 : ((W+1)'(w_py) - (W+1)'(r_start_y));
    assign w_dh = w_cmd_start ? '0 : ((HEAD_WIDTH+1)'(r_start_h) - (HEAD_WIDTH+1)'(w_ph));
    assign w_ax = w_dx[W] ? W'(-w_dx) : W'(w_dx);
    assign w_ay = w_dy[W] ? W'(-w_dy) : W'(w_dy);

    ssdc_square #(.VALUE_WIDTH(W)) u_square_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sq_start),
        .i_value  (w_ax),
        .o_square (w_sqx),
        .o_busy   (w_sqx_busy)
    );

    ssdc_square #(.VALUE_WIDTH(W)) u_square_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sq_start),
        .i_value  (w_ay),
        .o_square (w_sqy),
        .o_busy   (w_sqy_busy)
    );

    assign w_sum = SUM_W'(w_sqx) + SUM_W'(w_sqy);

    generate
        if (SUM_W > SUM_LIMIT_BITS) begin : g_sum_sat
            assign w_sum_clip = (|w_sum[SUM_W-1:SUM_LIMIT_BITS]) ?
                                SUM_W'({SUM_LIMIT_BITS{1'b1}}) : w_sum;
        end else begin : g_sum_plain
            assign w_sum_clip = w_sum;
        end
    endgenerate

    ssdc_sqrt #(.ROOT_WIDTH(ROOT_W)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rt_start),
        .i_radicand (RAD_W'(w_sum_clip)),
        .o_root     (w_root),
        .o_busy     (w_rt_busy)
    );

    ssdc_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_wr_start),
        .i_diff  (w_dh),
        .o_err   (w_err),
        .o_busy  (w_wr_busy)
    );

    assign w_tgt_abs = r_target[TARGET_WIDTH-1] ?
                       ((TARGET_WIDTH+1)'(0) - (TARGET_WIDTH+1)'(r_target)) :
                       (TARGET_WIDTH+1)'(r_target);

    // speed magnitude: cruise, or twice the remaining distance held above the floor
    assign w_reached = (r_rem <= $signed(REMW'(r_stop_tol)));
    assign w_near    = (r_rem <  $signed(REMW'(r_slow)));
    assign w_twice   = {r_rem, 1'b0};
    assign w_min_m   = MAG_W'(r_min_speed);

    always_comb begin
        if (w_near) begin
            w_mag = (w_twice < w_min_m) ? w_min_m : w_twice;
        end else begin
            w_mag = MAG_W'(r_cruise);
        end
        if (r_target[TARGET_WIDTH-1]) begin
            w_lin = (w_mag > MAG_W'(OUT_NEG_LIMIT)) ? OUT_MIN :
                    OUT_WIDTH'(MAG_W'(0) - w_mag);
        end else begin
            w_lin = (w_mag > MAG_W'(OUT_POS_LIMIT)) ? OUT_MAX : OUT_WIDTH'(w_mag);
        end
    end

    assign w_err2 = $signed({w_err, 1'b0});
    assign w_ang  = (w_err2 > OUT_MAX) ? OUT_MAX :
                    (w_err2 < OUT_MIN) ? OUT_MIN : OUT_WIDTH'(w_err2);

    assign w_out_free = !r_m_valid || m_axis_tready;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_start_h  = r_start_h;
        n_active   = r_active;
        n_skip     = r_skip;
        n_rem      = r_rem;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_m_done   = r_m_done;
        w_sq_start = 1'b0;
        w_rt_start = 1'b0;
        w_wr_start = 1'b0;
        s_axis_tready = (r_state == ST_IDLE);

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_cmd_start) begin
                        n_start_x = w_px;
                        n_start_y = w_py;
                        n_start_h = w_ph;
                        n_active  = 1'b1;
                    end
                    if ((s_axis_tuser == CMD_SAMPLE) && !r_active) begin
                        n_skip  = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        n_skip     = 1'b0;
                        w_sq_start = 1'b1;
                        w_wr_start = 1'b1;
                        n_state    = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                if (!w_sqx_busy && !w_sqy_busy) begin
                    w_rt_start = 1'b1;
                    n_state    = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (!w_rt_busy) begin
                    n_rem   = $signed(REMW'(w_tgt_abs)) - $signed(REMW'(w_root[QW-1:0]));
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if ((r_skip || !w_wr_busy) && w_out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = ST_IDLE;
                    if (r_skip || w_reached) begin
                        n_m_data = '0;
                        n_m_done = 1'b1;
                    end else begin
                        n_m_data = {w_ang, w_lin};
                        n_m_done = 1'b0;
                    end
                    // close the segment once inside tolerance
                    if (!r_skip && w_reached) begin
                        n_active = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_skip      <= 1'b0;
            r_m_valid   <= 1'b0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_start_h   <= '0;
            r_target    <= RST_TARGET_DISTANCE;
            r_cruise    <= RST_CRUISE_SPEED;
            r_slow      <= RST_SLOWDOWN_RADIUS;
            r_min_speed <= RST_MIN_SPEED;
            r_stop_tol  <= RST_STOP_TOLERANCE;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_skip    <= n_skip;
            r_m_valid <= n_m_valid;
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
            r_start_h <= n_start_h;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TARGET_DISTANCE: r_target    <= i_cfg_wdata;
                    CFG_CRUISE_SPEED:    r_cruise    <= i_cfg_wdata[GAIN_WIDTH-1:0];
                    CFG_SLOWDOWN_RADIUS: r_slow      <= i_cfg_wdata[GAIN_WIDTH-1:0];
                    CFG_MIN_SPEED:       r_min_speed <= i_cfg_wdata[GAIN_WIDTH-1:0];
                    CFG_STOP_TOLERANCE:  r_stop_tol  <= i_cfg_wdata[GAIN_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_m_data <= n_m_data;
        r_m_done <= n_m_done;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_done;

    `SSDC_ASSERT_NOW(a_done_is_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "done result carries nonzero commands")
    `SSDC_ASSERT_NEXT(a_start_opens, w_accept && w_cmd_start, r_active, "start transfer did not open a segment")
    `SSDC_ASSERT_NEXT(a_no_overwrite, (r_state == ST_FINISH) && r_m_valid && !m_axis_tready, (r_state == ST_FINISH) && r_m_valid, "pending result overwritten")
    `SSDC_ASSERT_NOW(a_units_idle, r_state == ST_IDLE, !w_sqx_busy && !w_sqy_busy && !w_rt_busy, "arithmetic unit busy while idle")

endmodule

[hw/rtl/ssdc_square.sv]
// ----------------------------------------------------------------------------
// ssdc_square
// Radix-4 shift-add squarer: two multiplier bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module ssdc_square #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [VALUE_WIDTH-1:0]     i_value,
    output logic [2*VALUE_WIDTH-1:0]   o_square,
    output logic                       o_busy
);

    localparam int MW    = VALUE_WIDTH + (VALUE_WIDTH % 2);
    localparam int STEPS = MW / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ACC_W = 2 * VALUE_WIDTH;

    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH+1:0] r_a3;
    logic [MW-1:0]          r_b;
    logic [ACC_W-1:0]       r_acc;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic [ACC_W-1:0]       w_mult;
    logic [1:0]             w_digit;

    assign w_digit = r_b[MW-1 -: 2];

    always_comb begin
        unique case (w_digit)
            2'd0: w_mult = '0;
            2'd1: w_mult = ACC_W'(r_a);
            2'd2: w_mult = ACC_W'({r_a, 1'b0});
            2'd3: w_mult = ACC_W'(r_a3);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_value;
            r_a3  <= (VALUE_WIDTH+2)'(i_value) + (VALUE_WIDTH+2)'({i_value, 1'b0});
            r_b   <= MW'(i_value);
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[MW-3:0], 2'b00};
            r_acc <= {r_acc[ACC_W-3:0], 2'b00} + w_mult;
        end
    end

    assign o_square = r_acc;
    assign o_busy   = r_busy;

endmodule

[hw/rtl/ssdc_sqrt.sv]
// ----------------------------------------------------------------------------
// ssdc_sqrt
// Restoring integer square root, two root bits per cycle, radicand MSB first.
// ----------------------------------------------------------------------------
module ssdc_sqrt #(
    parameter int ROOT_WIDTH = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*ROOT_WIDTH-1:0]   i_radicand,
    output logic [ROOT_WIDTH-1:0]     o_root,
    output logic                      o_busy
);

    localparam int RAD_W = 2 * ROOT_WIDTH;
    localparam int REM_W = ROOT_WIDTH + 2;
    localparam int STEPS = ROOT_WIDTH / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_WIDTH-1:0] r_root;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic [REM_W-1:0]      n_rem;
    logic [ROOT_WIDTH-1:0] n_root;

    // two dependent compare-subtract steps per cycle
    always_comb begin
        logic [REM_W-1:0] trial;
        n_rem  = r_rem;
        n_root = r_root;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[REM_W-3:0], r_rad[RAD_W-1-2*k -: 2]};
            trial = {n_root, 2'b01};
            if (n_rem >= trial) begin
                n_rem  = n_rem - trial;
                n_root = {n_root[ROOT_WIDTH-2:0], 1'b1};
            end else begin
                n_root = {n_root[ROOT_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-5:0], 4'b0000};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;

endmodule

[hw/rtl/ssdc_wrap.sv]
// ----------------------------------------------------------------------------
// ssdc_wrap
// Heading error wrap: adds or removes one full turn per cycle until in range.
// ----------------------------------------------------------------------------
module ssdc_wrap #(
    parameter int FRAC_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ssdc_pkg::HEAD_WIDTH:0]   i_diff,
    output logic signed [ssdc_pkg::HERR_WIDTH-1:0] o_err,
    output logic                                   o_busy
);

    import ssdc_pkg::*;

    localparam longint unsigned PI_L = ((PI_Q30 >> (29 - FRAC_BITS)) + 64'd1) >> 1;
    localparam logic signed [HERR_WIDTH-1:0] PI_POS = HERR_WIDTH'(PI_L);
    localparam logic signed [HERR_WIDTH-1:0] PI_NEG = -PI_POS;
    localparam logic signed [HERR_WIDTH-1:0] TWO_PI = HERR_WIDTH'(2 * PI_L);

    logic signed [HERR_WIDTH-1:0] r_err;
    logic signed [HERR_WIDTH-1:0] n_err;
    logic                         w_above;
    logic                         w_below;

    assign w_above = (r_err > PI_POS);
    assign w_below = (r_err < PI_NEG);

    always_comb begin
        n_err = r_err;
        priority if (i_start) begin
            n_err = HERR_WIDTH'(i_diff);
        end else if (w_above) begin
            n_err = r_err - TWO_PI;
        end else if (w_below) begin
            n_err = r_err + TWO_PI;
        end else begin
            n_err = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= '0;
        end else begin
            r_err <= n_err;
        end
    end

    assign o_err  = r_err;
    assign o_busy = w_above || w_below;

endmodule
